// ----- rtl/core/ils_pkg.sv -----
package ils_pkg;

    // operation codes
    localparam logic [2:0] OP_APPEND = 3'd0;
    localparam logic [2:0] OP_REMOVE = 3'd1;
    localparam logic [2:0] OP_READ   = 3'd2;
    localparam logic [2:0] OP_WRITE  = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    localparam logic signed [31:0] READ_MISS = -32'sd1;

    // request beat
    typedef struct packed {
        logic [2:0]         op;
        logic [7:0]         index;
        logic signed [31:0] value;
    } req_t;

    // response beat
    typedef struct packed {
        logic signed [31:0] read_data;
        logic [4:0]         count;
        logic [1:0]         status;
    } rsp_t;

    // per-beat commands broadcast to every cell
    typedef struct packed {
        logic app;   // append accepted (list not full)
        logic rem;   // remove with a valid index
        logic wr;    // overwrite with a valid index
    } cell_ctrl_t;

endpackage

// ----- rtl/core/ils_cell.sv -----
module ils_cell #(
    parameter int AW = 4
) (
    input  logic                clk,
    input  ils_pkg::cell_ctrl_t ctrl,
    input  logic [AW-1:0]       pos,
    input  logic [AW-1:0]       idx,
    input  logic [AW-1:0]       tail_idx,
    input  logic [AW-1:0]       last_idx,
    input  logic signed [31:0]  value,
    input  logic signed [31:0]  upper_data,
    output logic signed [31:0]  entry,
    output logic signed [31:0]  read_part
);

    logic signed [31:0] entry_reg;
    logic signed [31:0] entry_next;
    logic               hit;

    assign hit = (pos == idx);

    // load from the request, take the upper neighbor on remove, or hold
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.app && (pos == tail_idx))
        begin
            entry_next = value;
        end
        else if (ctrl.wr && hit)
        begin
            entry_next = value;
        end
        else if (ctrl.rem && (pos >= idx) && (pos < last_idx))
        begin
            entry_next = upper_data;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    // contribution to the read bus
    assign entry     = entry_reg;
    assign read_part = hit ? entry_reg : 32'sd0;

endmodule

// ----- rtl/core/indexed_list_store_core.sv -----
// Bounded ordered list of signed 32-bit values held in a row of DEPTH entry
// cells. Each request beat carries one operation (append, remove at index,
// read at index, overwrite at index, clear) and yields one response beat with
// the read value, the entry count after the operation (low 5 bits) and a
// status. Every operation, remove included, is applied at once: on remove
// every cell from the index up to the one below the last entry loads its
// upper neighbor, so a new request is taken each cycle while the response
// register drains; the response is registered and appears in the cycle
// after acceptance, and a stalled response holds off the next request. An
// index at or beyond the count leaves the list as is and reports bad index;
// a bad read returns -1. An append to a full list is dropped and reported.
// Entry cells are not reset; only entries below the count are ever read.
module indexed_list_store_core #(
    parameter int DEPTH = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  ils_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output ils_pkg::rsp_t rsp
);

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > 8) ? CW : 8;

    logic [CW-1:0]       fill_reg;
    logic [CW-1:0]       fill_next;
    logic                rsp_valid_reg;
    ils_pkg::rsp_t       rsp_reg;
    ils_pkg::rsp_t       rsp_next;

    logic                accept;
    logic                full;
    logic                idx_ok;
    logic [CW-1:0]       fill_dec;
    logic [AW-1:0]       idx_a;
    logic [AW-1:0]       tail_idx;
    logic [AW-1:0]       last_idx;
    logic [CW+4:0]       fill_wide;
    logic signed [31:0]  read_bus;
    ils_pkg::cell_ctrl_t ctrl;

    logic signed [31:0]  entries   [DEPTH];
    logic signed [31:0]  read_part [DEPTH];

    // handshake: take a beat unless a finished response is stuck
    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;

    // index checks and cell addressing
    assign full     = (fill_reg == CW'(DEPTH));
    assign idx_ok   = (CMPW'(req.index) < CMPW'(fill_reg));
    assign fill_dec = fill_reg - CW'(1);
    assign idx_a    = req.index[AW-1:0];
    assign tail_idx = fill_reg[AW-1:0];
    assign last_idx = fill_dec[AW-1:0];

    // commands to the cells
    always_comb
    begin
        ctrl.app = accept && (req.op == ils_pkg::OP_APPEND) && !full;
        ctrl.rem = accept && (req.op == ils_pkg::OP_REMOVE) && idx_ok;
        ctrl.wr  = accept && (req.op == ils_pkg::OP_WRITE) && idx_ok;
    end

    // row of entry cells, each fed by its upper neighbor
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic signed [31:0] upper;
        if (g == DEPTH - 1)
        begin : g_top
            assign upper = 32'sd0;
        end
        else
        begin : g_mid
            assign upper = entries[g+1];
        end

        ils_cell #(
            .AW(AW)
        ) u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .pos       (AW'(g)),
            .idx       (idx_a),
            .tail_idx  (tail_idx),
            .last_idx  (last_idx),
            .value     (req.value),
            .upper_data(upper),
            .entry     (entries[g]),
            .read_part (read_part[g])
        );
    end

    // read bus: or of the one hit cell
    always_comb
    begin
        read_bus = 32'sd0;
        for (int k = 0; k < DEPTH; k++)
        begin
            read_bus = read_bus | read_part[k];
        end
    end

    // next fill count and response
    always_comb
    begin
        fill_next          = fill_reg;
        rsp_next.read_data = 32'sd0;
        rsp_next.status    = ils_pkg::ST_OK;
        case (req.op)
            ils_pkg::OP_APPEND:
            begin
                if (full)
                    rsp_next.status = ils_pkg::ST_FULL;
                else
                    fill_next = fill_reg + CW'(1);
            end
            ils_pkg::OP_REMOVE:
            begin
                if (idx_ok)
                    fill_next = fill_dec;
                else
                    rsp_next.status = ils_pkg::ST_BAD_INDEX;
            end
            ils_pkg::OP_READ:
            begin
                if (idx_ok)
                begin
                    rsp_next.read_data = read_bus;
                end
                else
                begin
                    rsp_next.read_data = ils_pkg::READ_MISS;
                    rsp_next.status    = ils_pkg::ST_BAD_INDEX;
                end
            end
            ils_pkg::OP_WRITE:
            begin
                if (!idx_ok)
                    rsp_next.status = ils_pkg::ST_BAD_INDEX;
            end
            ils_pkg::OP_CLEAR:
            begin
                fill_next = '0;
            end
            default:
            begin
                fill_next = fill_reg;
            end
        endcase
        fill_wide      = (CW+5)'(fill_next);
        rsp_next.count = fill_wide[4:0];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                fill_reg      <= fill_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // response payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
